// ===== rtl/weekly_setpoint_scheduler_macros.svh =====
// Assertion helpers used by the checker of the scheduler.
`ifndef WEEKLY_SETPOINT_SCHEDULER_MACROS_SVH
`define WEEKLY_SETPOINT_SCHEDULER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define WSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define WSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

   localparam int DAYS_DEFAULT  = 7;
   localparam int SLOTS_DEFAULT = 6;

   localparam int TEMP_W    = 11;
   localparam int TIME_W    = 17;
   localparam int DAY_W     = 3;
   localparam int SLOT_W    = 4;
   localparam int HOUR_W    = 5;
   localparam int MIN_W     = 6;
   localparam int SEC_W     = 6;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_AUTO   = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_ABSENT = 2'd2,
      MODE_FROST  = 2'd3
   } heat_mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAT_MODE       = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_SETPOINT = 1'b1;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [HOUR_W-1:0] HOUR_MAX   = 5'd23;
   localparam logic [MIN_W-1:0]  MINUTE_MAX = 6'd59;
   localparam logic [SEC_W-1:0]  SECOND_MAX = 6'd59;
   localparam logic [TIME_W-1:0] SEC_PER_HOUR = 17'd3600;
   localparam logic [TIME_W-1:0] SEC_PER_MIN  = 17'd60;
   localparam int                SLOT_STEP    = 14400;
   localparam logic [TIME_W-1:0] START_MAX    = 17'h1FFFF;

   localparam logic signed [TEMP_W-1:0] RESET_TEMP     = 11'sd170;
   localparam logic signed [TEMP_W-1:0] MANUAL_RESET   = 11'sd200;
   localparam logic signed [TEMP_W-1:0] ABSENT_OFFSET  = 11'sd40;
   localparam logic signed [TEMP_W-1:0] BAD_DAY_TEMP   = -11'sd10;
   localparam logic signed [TEMP_W-1:0] BAD_DAY_ABSENT = -11'sd50;
   localparam logic signed [TEMP_W-1:0] FROST_HIGH     = 11'sd120;
   localparam logic signed [TEMP_W-1:0] FROST_LOW      = 11'sd80;
   localparam logic signed [TEMP_W-1:0] FROST_RAMP_END = 11'sd100;
   localparam logic signed [TEMP_W-1:0] ZERO_TEMP      = 11'sd0;

   // One input word as captured by the datapath.
   typedef struct packed {
      logic                     action;
      logic [DAY_W-1:0]         day;
      logic [SLOT_W-1:0]        slot;
      logic [HOUR_W-1:0]        hour;
      logic [MIN_W-1:0]         minute;
      logic [SEC_W-1:0]         second;
      logic signed [TEMP_W-1:0] slot_temp;
      logic [TIME_W-1:0]        time_of_day;
      logic signed [TEMP_W-1:0] outdoor_temp;
   } wss_req_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic scan_step;
      logic respond;
   } wss_cmd_type;

   typedef struct packed {
      logic is_scan;
      logic scan_last;
      logic out_free;
   } wss_stat_type;

   // Start time a slot holds before it is first written.
   function automatic logic [TIME_W-1:0] reset_start(input logic [SLOT_W-1:0] slot);
      logic [TIME_W+2:0] s;
      s = (TIME_W+3)'(slot) * (TIME_W+3)'(SLOT_STEP);
      return (s > (TIME_W+3)'(START_MAX)) ? START_MAX : s[TIME_W-1:0];
   endfunction

   // 120 - 0.4*ext rounded, ramp between 0 and 10 degrees outside.
   function automatic logic signed [TEMP_W-1:0] frost_target(
      input logic signed [TEMP_W-1:0] ext);
      logic [7:0]  x;
      logic [15:0] prod;
      logic [5:0]  q;
      x    = {ext[6:0], 1'b0} + 8'd2;
      // divide by five: multiply by 205/1024, exact below 1024
      prod = 16'(x) * 16'd205;
      q    = prod[15:10];
      if (ext[TEMP_W-1]) begin
         return FROST_HIGH;
      end else if (ext <= FROST_RAMP_END) begin
         return FROST_HIGH - $signed(TEMP_W'(q));
      end else begin
         return FROST_LOW;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wss_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wss_req_if import wss_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [DAY_W-1:0]         day;
   logic [SLOT_W-1:0]        slot;
   logic [HOUR_W-1:0]        hour;
   logic [MIN_W-1:0]         minute;
   logic [SEC_W-1:0]         second;
   logic signed [TEMP_W-1:0] slot_temp;
   logic [TIME_W-1:0]        time_of_day;
   logic signed [TEMP_W-1:0] outdoor_temp;

   modport source (
      output valid, action, day, slot, hour, minute, second, slot_temp,
             time_of_day, outdoor_temp,
      input  ready
   );
   modport sink (
      input  valid, action, day, slot, hour, minute, second, slot_temp,
             time_of_day, outdoor_temp,
      output ready
   );
endinterface

interface wss_rsp_if import wss_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] target_temp;
   logic                     status;

   modport source (output valid, target_temp, status, input ready);
   modport sink (input valid, target_temp, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/weekly_setpoint_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Weekly setpoint scheduler: holds DAYS x SLOTS timed temperature slots and answers
// target-temperature queries for the selected heating mode. One word is worked on at a
// time. A write, or a query in manual or frost mode or with a bad day, goes through
// capture, decode and respond, and its result is written to the output register at the
// respond step. A schedule query in auto or absent mode adds a scan step between decode
// and respond: the slot memory has one read port and the scan compares one slot per
// cycle. The respond step stalls while an earlier result still waits in the output
// register. The next word is accepted once the result sits in the output register, even
// while that result still waits to be taken. Ready rises in the cycle after reset is
// released.
// Slots never written read as their reset start and 17.0 degrees through per-entry valid
// bits, so the block is ready straight out of reset with no clearing pass.
module weekly_setpoint_scheduler import wss_pkg::*; #(
   parameter int DAYS  = DAYS_DEFAULT,
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wss_req_if.sink                    req_bus,
   wss_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [TEMP_W-1:0]     csr_wdata
);

   heat_mode_type            heat_mode_ff;
   logic signed [TEMP_W-1:0] manual_ff;
   wss_req_type              req_word;
   wss_cmd_type              cmd;
   wss_stat_type             stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_mode_ff <= MODE_AUTO;
         manual_ff    <= MANUAL_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HEAT_MODE:       heat_mode_ff <= heat_mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_MANUAL_SETPOINT: manual_ff    <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   assign req_word.action       = req_bus.action;
   assign req_word.day          = req_bus.day;
   assign req_word.slot         = req_bus.slot;
   assign req_word.hour         = req_bus.hour;
   assign req_word.minute       = req_bus.minute;
   assign req_word.second       = req_bus.second;
   assign req_word.slot_temp    = req_bus.slot_temp;
   assign req_word.time_of_day  = req_bus.time_of_day;
   assign req_word.outdoor_temp = req_bus.outdoor_temp;

   wss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wss_datapath #(
      .DAYS  (DAYS),
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_word        (req_word),
      .heat_mode       (heat_mode_ff),
      .manual_setpoint (manual_ff),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_target_temp (rsp_bus.target_temp),
      .rsp_status      (rsp_bus.status)
   );

endmodule

`default_nettype wire

// ===== rtl/wss_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wss_ctrl import wss_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire wss_stat_type stat,
   output wss_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_RESPOND
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= ST_DECODE;
                  req_ready_ff <= 1'b0;
               end else begin
                  // raise ready once out of reset
                  req_ready_ff <= 1'b1;
               end
            end
            ST_DECODE: begin
               state_ff <= stat.is_scan ? ST_SCAN : ST_RESPOND;
            end
            ST_SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= ST_RESPOND;
               end
            end
            ST_RESPOND: begin
               // hold until the output register is free
               if (stat.out_free) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready     = req_ready_ff;
   assign cmd.capture   = (state_ff == ST_IDLE) && req_valid && req_ready_ff;
   assign cmd.decode    = (state_ff == ST_DECODE);
   assign cmd.scan_step = (state_ff == ST_SCAN);
   assign cmd.respond   = (state_ff == ST_RESPOND) && stat.out_free;

endmodule

`default_nettype wire

// ===== rtl/wss_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wss_datapath import wss_pkg::*; #(
   parameter int DAYS  = DAYS_DEFAULT,
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire wss_cmd_type              cmd,
   output wss_stat_type                  stat,
   input  wire wss_req_type              req_word,
   input  wire heat_mode_type            heat_mode,
   input  wire logic signed [TEMP_W-1:0] manual_setpoint,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic signed [TEMP_W-1:0]      rsp_target_temp,
   output logic                          rsp_status
);

   localparam int NSLOT = DAYS * SLOTS;
   localparam int AW    = $clog2(NSLOT);
   localparam int SW    = $clog2(SLOTS);
   localparam int MW    = TIME_W + TEMP_W;
   localparam logic signed [TEMP_W:0] ABS_FLOOR = -(TEMP_W+1)'(2 ** (TEMP_W - 1));

   wss_req_type item_ff;

   logic [MW-1:0]    mem [NSLOT];
   logic [NSLOT-1:0] valid_ff;
   logic [MW-1:0]    rd_data_ff;
   logic             rd_valid_ff;
   logic [SW-1:0]    rd_slot_ff;
   logic [SW-1:0]    issue_idx_ff;

   logic [TIME_W-1:0]        last_ff;
   logic                     found_ff;
   logic signed [TEMP_W-1:0] best_ff;

   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic                     rsp_status_ff;

   logic                     day_ok;
   logic                     write_ok;
   logic                     is_scan;
   logic                     scan_last;
   logic [AW-1:0]            base;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr;
   logic [SW-1:0]            rd_idx;
   logic                     rd_en;
   logic [TIME_W-1:0]        start_sum;
   logic [TIME_W-1:0]        eff_start;
   logic signed [TEMP_W-1:0] eff_temp;
   logic                     hit;
   logic signed [TEMP_W:0]   sched_minus;
   logic signed [TEMP_W-1:0] absent_temp;
   logic signed [TEMP_W-1:0] res_temp;
   logic                     res_status;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
      end
   end

   // Check the decoded word
   assign day_ok   = {1'b0, item_ff.day} < (DAY_W+1)'(DAYS);
   assign write_ok = (item_ff.action == ACT_WRITE) && day_ok
                     && ({1'b0, item_ff.slot} < (SLOT_W+1)'(SLOTS))
                     && (item_ff.hour <= HOUR_MAX)
                     && (item_ff.minute <= MINUTE_MAX)
                     && (item_ff.second <= SECOND_MAX);
   assign is_scan  = (item_ff.action == ACT_QUERY) && day_ok
                     && ((heat_mode == MODE_AUTO) || (heat_mode == MODE_ABSENT));

   assign base      = AW'(item_ff.day * SLOTS);
   assign wr_addr   = base + AW'(item_ff.slot);
   assign start_sum = TIME_W'(item_ff.hour) * SEC_PER_HOUR
                      + TIME_W'(item_ff.minute) * SEC_PER_MIN
                      + TIME_W'(item_ff.second);

   assign scan_last = (rd_slot_ff == SW'(SLOTS - 1));
   assign rd_idx    = cmd.decode ? '0 : issue_idx_ff;
   assign rd_addr   = base + AW'(rd_idx);
   assign rd_en     = (cmd.decode && is_scan) || (cmd.scan_step && !scan_last);

   // Schedule memory
   always_ff @(posedge clock) begin
      if (cmd.decode && write_ok) begin
         mem[wr_addr] <= {start_sum, item_ff.slot_temp};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.decode && write_ok) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff  <= valid_ff[rd_addr];
         rd_slot_ff   <= rd_idx;
         issue_idx_ff <= rd_idx + SW'(1);
      end
   end

   // Slots never written read as their reset contents
   assign eff_start = rd_valid_ff ? rd_data_ff[MW-1:TEMP_W]
                                  : reset_start(SLOT_W'(rd_slot_ff));
   assign eff_temp  = rd_valid_ff ? $signed(rd_data_ff[TEMP_W-1:0]) : RESET_TEMP;
   assign hit       = (item_ff.time_of_day >= eff_start) && (eff_start >= last_ff);

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         last_ff  <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (hit) begin
            last_ff  <= eff_start;
            found_ff <= 1'b1;
            best_ff  <= eff_temp;
         end else if (scan_last && !found_ff) begin
            // no start at or before the time: fall back to the last slot
            best_ff <= eff_temp;
         end
      end
   end

   assign sched_minus = $signed({best_ff[TEMP_W-1], best_ff})
                        - $signed({ABSENT_OFFSET[TEMP_W-1], ABSENT_OFFSET});
   assign absent_temp = (sched_minus < ABS_FLOOR) ? ABS_FLOOR[TEMP_W-1:0]
                                                  : sched_minus[TEMP_W-1:0];

   always_comb begin
      res_temp   = ZERO_TEMP;
      res_status = 1'b0;
      if (item_ff.action == ACT_WRITE) begin
         res_status = !write_ok;
      end else begin
         unique case (heat_mode)
            MODE_MANUAL: begin
               res_temp = manual_setpoint;
            end
            MODE_FROST: begin
               res_temp = frost_target(item_ff.outdoor_temp);
            end
            MODE_ABSENT: begin
               res_temp   = day_ok ? absent_temp : BAD_DAY_ABSENT;
               res_status = !day_ok;
            end
            default: begin
               res_temp   = day_ok ? best_ff : BAD_DAY_TEMP;
               res_status = !day_ok;
            end
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_temp_ff   <= res_temp;
         rsp_status_ff <= res_status;
      end
   end

   assign stat.is_scan   = is_scan;
   assign stat.scan_last = scan_last;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target_temp = rsp_temp_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/wss_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "weekly_setpoint_scheduler_macros.svh"

module wss_checker import wss_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [TEMP_W-1:0] rsp_target_temp,
   input wire logic                     rsp_status
);

   `WSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response word dropped while stalled")
   `WSS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_target_temp) && $stable(rsp_status), "response word changed while stalled")
   // one word in flight: ready must drop straight after an accept
   `WSS_ASSERT_NEXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready, "second word accepted while busy")
   // an error response only carries one of the fixed error targets
   `WSS_ASSERT_SAME(a_err_value, clock, reset, rsp_valid && rsp_status, rsp_target_temp == ZERO_TEMP || rsp_target_temp == BAD_DAY_TEMP || rsp_target_temp == BAD_DAY_ABSENT, "unexpected target on error response")

endmodule

bind weekly_setpoint_scheduler wss_checker u_wss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_target_temp (rsp_bus.target_temp),
   .rsp_status      (rsp_bus.status)
);

`default_nettype wire

// ===== verif/tb_weekly_setpoint_scheduler.sv =====
`timescale 1ns / 1ps

module tb_weekly_setpoint_scheduler;
   import wss_pkg::*;

   localparam int NDAYS         = DAYS_DEFAULT;
   localparam int NSLOTS        = SLOTS_DEFAULT;
   localparam int NENTRY        = NDAYS * NSLOTS;
   localparam int SETTLE_CYCLES = NSLOTS + 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 125;
   localparam bit EXACT         = 1'b1;
   localparam bit PREDICTED     = 1'b0;

   typedef struct packed {
      logic signed [TEMP_W-1:0] target_temp;
      logic                     status;
   } setpoint_reply_type;

   typedef struct {
      heat_mode_type            mode;
      logic signed [TEMP_W-1:0] manual;
      wss_req_type              word;
      bit                       exact;
      setpoint_reply_type       reply;
   } directed_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TEMP_W-1:0]    csr_wdata;

   wss_req_if req_bus ();
   wss_rsp_if rsp_bus ();

   weekly_setpoint_scheduler #(
      .DAYS  (NDAYS),
      .SLOTS (NSLOTS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Schedule predictor state
   heat_mode_type            mode_mdl;
   logic signed [TEMP_W-1:0] manual_mdl;
   logic [TIME_W-1:0]        start_mdl [NENTRY];
   logic signed [TEMP_W-1:0] temp_mdl [NENTRY];

   setpoint_reply_type expected_setpoints [$];
   directed_row_type   directed_rows [$];
   int                 mismatch_count  = 0;
   int                 idle_pct        = 30;
   int                 rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("weekly_setpoint_scheduler regression: fail");
      $finish;
   end

   function automatic int lookup_schedule(input logic [DAY_W-1:0] day,
         input logic [TIME_W-1:0] now, output logic bad_day);
      int base;
      int latest;
      int t;
      bad_day = 1'b0;
      if (int'(day) >= NDAYS) begin
         bad_day = 1'b1;
         return int'(BAD_DAY_TEMP);
      end
      base   = int'(day) * NSLOTS;
      t      = temp_mdl[base + NSLOTS - 1];
      latest = 0;
      for (int i = 0; i < NSLOTS; i++) begin
         // ties go to the later slot
         if (now >= start_mdl[base + i] && int'(start_mdl[base + i]) >= latest) begin
            latest = int'(start_mdl[base + i]);
            t      = temp_mdl[base + i];
         end
      end
      return t;
   endfunction

   function automatic setpoint_reply_type compute_setpoint(input wss_req_type w);
      setpoint_reply_type r;
      int                 t;
      int                 ext;
      int                 k;
      logic               bad;
      r.target_temp = ZERO_TEMP;
      r.status      = 1'b0;
      if (w.action == ACT_WRITE) begin
         if (int'(w.day) >= NDAYS || int'(w.slot) >= NSLOTS || w.hour > HOUR_MAX
               || w.minute > MINUTE_MAX || w.second > SECOND_MAX) begin
            r.status = 1'b1;
         end else begin
            k = int'(w.day) * NSLOTS + int'(w.slot);
            start_mdl[k] = TIME_W'(int'(w.hour) * int'(SEC_PER_HOUR)
                                   + int'(w.minute) * int'(SEC_PER_MIN) + int'(w.second));
            temp_mdl[k]  = $signed(w.slot_temp);
         end
      end else begin
         case (mode_mdl)
            MODE_MANUAL: begin
               r.target_temp = manual_mdl;
            end
            MODE_ABSENT: begin
               t = lookup_schedule(w.day, w.time_of_day, bad) - int'(ABSENT_OFFSET);
               r.status      = bad;
               r.target_temp = TEMP_W'((t < -1024) ? -1024 : t);
            end
            MODE_FROST: begin
               ext = $signed(w.outdoor_temp);
               if (ext < 0) begin
                  t = int'(FROST_HIGH);
               end else if (ext <= int'(FROST_RAMP_END)) begin
                  t = int'(FROST_HIGH) - (2 * ext + 2) / 5;
               end else begin
                  t = int'(FROST_LOW);
               end
               r.target_temp = TEMP_W'(t);
            end
            default: begin
               t = lookup_schedule(w.day, w.time_of_day, bad);
               r.status      = bad;
               r.target_temp = TEMP_W'(t);
            end
         endcase
      end
      return r;
   endfunction

   function automatic wss_req_type slot_write(int day, int slot, int hour, int minute,
         int second, int temp);
      wss_req_type w;
      w           = '0;
      w.action    = ACT_WRITE;
      w.day       = DAY_W'(day);
      w.slot      = SLOT_W'(slot);
      w.hour      = HOUR_W'(hour);
      w.minute    = MIN_W'(minute);
      w.second    = SEC_W'(second);
      w.slot_temp = TEMP_W'(temp);
      return w;
   endfunction

   function automatic wss_req_type target_query(int day, int tod, int ext);
      wss_req_type w;
      w              = '0;
      w.action       = ACT_QUERY;
      w.day          = DAY_W'(day);
      w.time_of_day  = TIME_W'(tod);
      w.outdoor_temp = TEMP_W'(ext);
      return w;
   endfunction

   function automatic void add_row(heat_mode_type mode, int manual, wss_req_type word,
         bit exact, int want_temp = 0, int want_status = 0);
      directed_row_type row;
      row.mode              = mode;
      row.manual            = TEMP_W'(manual);
      row.word              = word;
      row.exact             = exact;
      row.reply.target_temp = TEMP_W'(want_temp);
      row.reply.status      = want_status[0];
      directed_rows.push_back(row);
   endfunction

   // Mostly well-formed words with tie-prone start times, plus some raw noise.
   function automatic wss_req_type random_word();
      wss_req_type w;
      int          pick;
      int          day;
      int          k;
      pick = $urandom_range(0, 99);
      w    = wss_req_type'({$urandom, $urandom});
      if (pick < 8) begin
         return w;
      end
      day   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7)
                                           : $urandom_range(0, NDAYS - 1);
      w.day = DAY_W'(day);
      if (pick < 50) begin
         w.action = ACT_WRITE;
         if ($urandom_range(0, 19) != 0) begin
            w.slot = SLOT_W'($urandom_range(0, NSLOTS - 1));
         end
         if ($urandom_range(0, 19) != 0) begin
            w.hour = HOUR_W'($urandom_range(0, 1) ? 4 * $urandom_range(0, 5)
                                                  : $urandom_range(0, 23));
            w.minute = MIN_W'($urandom_range(0, 1) ? 0 : $urandom_range(0, 59));
            w.second = SEC_W'($urandom_range(0, 1) ? 0 : $urandom_range(0, 59));
         end
         if ($urandom_range(0, 9) != 0) begin
            w.slot_temp = TEMP_W'(int'($urandom_range(0, 1500)) - 500);
         end
      end else begin
         w.action = ACT_QUERY;
         pick     = $urandom_range(0, 9);
         if (pick < 4 && day < NDAYS) begin
            // land on a slot start or just short of it
            k = day * NSLOTS + $urandom_range(0, NSLOTS - 1);
            w.time_of_day = start_mdl[k] - TIME_W'($urandom_range(0, 1));
         end else if (pick < 9) begin
            w.time_of_day = TIME_W'($urandom_range(0, 86399));
         end
         if ($urandom_range(0, 4) != 0) begin
            w.outdoor_temp = TEMP_W'(int'($urandom_range(0, 200)) - 50);
         end
      end
      return w;
   endfunction

   task automatic offer_word(input wss_req_type w);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= w.action;
      req_bus.day          <= w.day;
      req_bus.slot         <= w.slot;
      req_bus.hour         <= w.hour;
      req_bus.minute       <= w.minute;
      req_bus.second       <= w.second;
      req_bus.slot_temp    <= w.slot_temp;
      req_bus.time_of_day  <= w.time_of_day;
      req_bus.outdoor_temp <= w.outdoor_temp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_setpoints.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(input heat_mode_type mode,
         input logic signed [TEMP_W-1:0] manual);
      drain_results();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_HEAT_MODE;
      csr_wdata    <= TEMP_W'(mode);
      @(posedge clock);
      csr_index    <= CSR_MANUAL_SETPOINT;
      csr_wdata    <= manual;
      @(posedge clock);
      csr_write_en <= 1'b0;
      mode_mdl   = mode;
      manual_mdl = manual;
   endtask

   initial begin : receiver
      setpoint_reply_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_setpoints.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected word: target_temp %0d status %0d",
                           $signed(rsp_bus.target_temp), rsp_bus.status);
               end
            end else begin
               want = expected_setpoints.pop_front();
               if (rsp_bus.target_temp !== want.target_temp
                     || rsp_bus.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("mismatch: target_temp exp %0d got %0d, status exp %0d got %0d",
                              $signed(want.target_temp), $signed(rsp_bus.target_temp),
                              want.status, rsp_bus.status);
                  end
               end
            end
         end
         // hold off the result side so the block backs up
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   initial begin : stimulus
      wss_req_type              w;
      setpoint_reply_type       r;
      int                       s;
      heat_mode_type            phase_mode;
      logic signed [TEMP_W-1:0] phase_manual;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_WRITE;
      req_bus.day          = '0;
      req_bus.slot         = '0;
      req_bus.hour         = '0;
      req_bus.minute       = '0;
      req_bus.second       = '0;
      req_bus.slot_temp    = '0;
      req_bus.time_of_day  = '0;
      req_bus.outdoor_temp = '0;
      csr_write_en         = 1'b0;
      csr_index            = CSR_HEAT_MODE;
      csr_wdata            = '0;

      mode_mdl   = MODE_AUTO;
      manual_mdl = MANUAL_RESET;
      for (int k = 0; k < NENTRY; k++) begin
         s            = (k % NSLOTS) * SLOT_STEP;
         start_mdl[k] = (s > int'(START_MAX)) ? START_MAX : TIME_W'(s);
         temp_mdl[k]  = RESET_TEMP;
      end

      add_row(MODE_AUTO, 200, target_query(0, 0, 0), EXACT, 170, 0);
      add_row(MODE_AUTO, 200, target_query(7, 0, 0), EXACT, -10, 1);
      add_row(MODE_AUTO, 200, slot_write(7, 0, 0, 0, 0, 100), EXACT, 0, 1);
      add_row(MODE_AUTO, 200, slot_write(0, NSLOTS, 0, 0, 0, 100), EXACT, 0, 1);
      add_row(MODE_AUTO, 200, slot_write(0, 0, 24, 0, 0, 100), EXACT, 0, 1);
      add_row(MODE_AUTO, 200, slot_write(0, 0, 0, 60, 0, 100), EXACT, 0, 1);
      add_row(MODE_AUTO, 200, slot_write(0, 0, 0, 0, 60, 100), EXACT, 0, 1);
      add_row(MODE_AUTO, 200, slot_write(0, 15, 31, 63, 63, -1024), EXACT, 0, 1);
      add_row(MODE_AUTO, 200, slot_write(0, 0, 23, 59, 59, 1000), EXACT, 0, 0);
      add_row(MODE_AUTO, 200, slot_write(6, 5, 0, 0, 0, -500), EXACT, 0, 0);
      add_row(MODE_AUTO, 200, target_query(0, 86399, 0), PREDICTED);
      // no start at or before midnight: falls back to the last slot
      add_row(MODE_AUTO, 200, target_query(0, 0, 0), PREDICTED);
      add_row(MODE_AUTO, 200, target_query(6, 0, 0), PREDICTED);
      add_row(MODE_AUTO, 200, target_query(1, 131071, -1024), PREDICTED);
      add_row(MODE_AUTO, 200, target_query(2, 14400, 1023), PREDICTED);
      add_row(MODE_AUTO, 200, slot_write(5, 0, 0, 0, 0, -1024), EXACT, 0, 0);
      add_row(MODE_ABSENT, 200, target_query(5, 100, 0), EXACT, -1024, 0);
      add_row(MODE_ABSENT, 200, target_query(7, 0, 0), EXACT, -50, 1);
      add_row(MODE_ABSENT, 200, target_query(6, 0, 0), PREDICTED);
      add_row(MODE_FROST, 200, target_query(7, 0, -1), EXACT, 120, 0);
      add_row(MODE_FROST, 200, target_query(0, 0, 0), EXACT, 120, 0);
      add_row(MODE_FROST, 200, target_query(0, 0, 3), PREDICTED);
      add_row(MODE_FROST, 200, target_query(0, 0, 100), EXACT, 80, 0);
      add_row(MODE_FROST, 200, target_query(0, 0, 101), EXACT, 80, 0);
      add_row(MODE_FROST, 200, target_query(0, 0, 1023), EXACT, 80, 0);
      add_row(MODE_FROST, 200, target_query(0, 0, -1024), EXACT, 120, 0);
      add_row(MODE_MANUAL, 1023, target_query(7, 0, 0), EXACT, 1023, 0);
      add_row(MODE_MANUAL, -1024, target_query(0, 0, 0), EXACT, -1024, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].mode != mode_mdl || directed_rows[i].manual != manual_mdl) begin
            set_registers(directed_rows[i].mode, directed_rows[i].manual);
         end
         offer_word(directed_rows[i].word);
         r = compute_setpoint(directed_rows[i].word);
         expected_setpoints.push_back(directed_rows[i].exact ? directed_rows[i].reply : r);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1:       phase_mode = MODE_ABSENT;
            3:       phase_mode = MODE_FROST;
            4, 6:    phase_mode = MODE_MANUAL;
            7:       phase_mode = heat_mode_type'($urandom_range(0, 3));
            default: phase_mode = MODE_AUTO;
         endcase
         if (phase == 4) begin
            phase_manual = -11'sd1024;
         end else if (phase == 6) begin
            phase_manual = 11'sd1023;
         end else begin
            phase_manual = TEMP_W'(int'($urandom_range(0, 1500)) - 500);
         end
         set_registers(phase_mode, phase_manual);
         idle_pct = (phase == 2) ? 0 : 30;
         if (phase == 5) begin
            rsp_hold_cycles = 400;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // pause the sender until everything is back
            if (phase == 3 && n == PHASE_WORDS / 2) begin
               drain_results();
            end
            w = random_word();
            offer_word(w);
            expected_setpoints.push_back(compute_setpoint(w));
         end
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("weekly_setpoint_scheduler regression: pass");
      end else begin
         $display("weekly_setpoint_scheduler regression: fail");
      end
      $finish;
   end

endmodule
